// File: src/spd_pkg.sv
// Shared types and constants for the parabola sub-pixel disparity block.
// Holds the port word structs and the internal pipeline word layouts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

	localparam int COST_BITS    = 16;
	localparam int FRAC_BITS    = 8;
	localparam int DISP_BITS    = 8;
	localparam int LEVEL_BITS   = 9;
	localparam int REFINED_BITS = DISP_BITS + FRAC_BITS;

	localparam logic [LEVEL_BITS-1:0] MAX_DISP_RESET = LEVEL_BITS'(64);
	localparam logic [LEVEL_BITS-1:0] MIN_LEVELS     = LEVEL_BITS'(2);

	typedef struct packed {
		logic [DISP_BITS-1:0] int_disparity;
		logic [COST_BITS-1:0] cost_below;
		logic [COST_BITS-1:0] cost_center;
		logic [COST_BITS-1:0] cost_above;
	} in_word_t;

	typedef struct packed {
		logic [REFINED_BITS-1:0] refined_disparity;
		logic [FRAC_BITS-1:0]    fraction_magnitude;
		logic                    fraction_negative;
	} out_word_t;

	// Numerator and denominator of the parabola vertex, before the division.
	typedef struct packed {
		logic [DISP_BITS-1:0]        disp;
		logic signed [COST_BITS:0]   num;
		logic signed [COST_BITS+2:0] den;
	} fit_word_t;

	// One word of the restoring divider pipeline.
	typedef struct packed {
		logic [DISP_BITS-1:0]   disp;
		logic [COST_BITS+1:0]   divisor;
		logic [COST_BITS+1:0]   rem;
		logic [FRAC_BITS-1:0]   quot;
		logic                   neg;
		logic                   zero;
		logic                   sat;
	} div_word_t;

endpackage
`default_nettype wire

// File: src/spd_front.sv
// Front end: neighbor mirroring, parabola numerator and denominator,
// then magnitudes, sign and special-case flags. Two pipeline stages.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [spd_pkg::LEVEL_BITS-1:0]  max_disparity,
	input  wire logic                            up_valid,
	output logic                                 up_ready,
	input  wire spd_pkg::in_word_t               up_word,
	output logic                                 dn_valid,
	input  wire logic                            dn_ready,
	output spd_pkg::div_word_t                   dn_word
);
	import spd_pkg::*;

	logic                  valid_s1;
	fit_word_t             fit_s1;
	logic                  ready_s1;
	fit_word_t             fit_d;
	logic [LEVEL_BITS-1:0] levels;
	logic [LEVEL_BITS-1:0] disp_next;
	logic                  at_top;
	logic [COST_BITS-1:0]  c0;
	logic [COST_BITS-1:0]  c2;
	logic [COST_BITS:0]    side_sum;

	logic                  valid_s2;
	div_word_t             div_s2;
	logic                  ready_s2;
	div_word_t             div_d;
	logic [COST_BITS:0]    num_abs;
	logic [COST_BITS+2:0]  den_abs;

	// Stage 1: pick the two neighbors and form the fit terms.
	always_comb begin
		levels    = (max_disparity < MIN_LEVELS) ? MIN_LEVELS : max_disparity;
		disp_next = {1'b0, up_word.int_disparity} + LEVEL_BITS'(1);
		at_top    = (disp_next >= levels);
		c0 = (up_word.int_disparity == '0) ? up_word.cost_above : up_word.cost_below;
		c2 = at_top ? up_word.cost_below : up_word.cost_above;
		side_sum = {1'b0, c0} + {1'b0, c2};
		fit_d.disp = up_word.int_disparity;
		fit_d.num  = $signed({1'b0, c0}) - $signed({1'b0, c2});
		fit_d.den  = $signed({1'b0, side_sum, 1'b0}) - $signed({1'b0, up_word.cost_center, 2'b00});
	end

	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			fit_s1 <= fit_d;
		end
	end

	// Stage 2: magnitudes and sign. When the numerator is not below the
	// denominator the quotient cannot fit and the result saturates.
	always_comb begin
		num_abs = fit_s1.num[COST_BITS] ? (-fit_s1.num) : fit_s1.num;
		den_abs = fit_s1.den[COST_BITS+2] ? (-fit_s1.den) : fit_s1.den;
		div_d.disp    = fit_s1.disp;
		div_d.divisor = den_abs[COST_BITS+1:0];
		div_d.rem     = {2'b00, num_abs[COST_BITS-1:0]};
		div_d.quot    = '0;
		div_d.neg     = fit_s1.num[COST_BITS] ^ fit_s1.den[COST_BITS+2];
		div_d.zero    = (fit_s1.num == '0) || (fit_s1.den == '0);
		div_d.sat     = ({2'b00, num_abs[COST_BITS-1:0]} >= den_abs[COST_BITS+1:0]);
	end

	assign ready_s2 = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			div_s2 <= div_d;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_word  = div_s2;

endmodule
`default_nettype wire

// File: src/spd_div_step.sv
// One stage of the restoring divider: produces one quotient bit per cycle while not stalled.
// Registered, with its own valid bit and stall handling.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_div_step (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire spd_pkg::div_word_t   up_word,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output spd_pkg::div_word_t        dn_word
);
	import spd_pkg::*;

	logic                 valid_s1;
	div_word_t            word_s1;
	div_word_t            word_d;
	logic [COST_BITS+2:0] shifted;
	logic [COST_BITS+2:0] diff;
	logic                 take;

	always_comb begin
		shifted = {up_word.rem, 1'b0};
		take    = (shifted >= {1'b0, up_word.divisor});
		diff    = shifted - {1'b0, up_word.divisor};
		word_d  = up_word;
		word_d.rem  = take ? diff[COST_BITS+1:0] : shifted[COST_BITS+1:0];
		word_d.quot = {up_word.quot[FRAC_BITS-2:0], take};
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= word_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule
`default_nettype wire

// File: src/subpixel_parabola_disparity_q8.sv
// Top level of the parabola sub-pixel disparity refinement block.
// Instantiates spd_front and a chain of spd_div_step; depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Takes one pixel word per clock while in_ready is high (integer disparity
// plus the costs at d-1, d and d+1) and returns one Q8.8 refined disparity
// word per pixel, in order. The block is a fully pipelined chain: two front
// stages for the fit terms, one restoring-divider stage per fraction bit, and
// an output stage; the rate is one word per cycle while out_ready is high.
// Each stage stalls only when it holds a word that the next cannot take, so
// bubbles are squeezed out under back-pressure.
// max_disparity may be written only while the pipeline is empty.
module subpixel_parabola_disparity_q8 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [spd_pkg::LEVEL_BITS-1:0]  cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire spd_pkg::in_word_t               in_word,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output spd_pkg::out_word_t                   out_word
);
	import spd_pkg::*;

	logic [LEVEL_BITS-1:0] max_disparity_q;
	logic                  div_valid [0:FRAC_BITS];
	logic                  div_ready [0:FRAC_BITS];
	div_word_t             div_word  [0:FRAC_BITS];

	logic                  valid_s3;
	out_word_t             word_s3;
	out_word_t             word_d;
	logic                  ready_s3;
	logic [FRAC_BITS-1:0]  mag;
	logic                  neg;
	logic [REFINED_BITS-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_disparity_q <= MAX_DISP_RESET;
		end else if (cfg_wr_en) begin
			max_disparity_q <= cfg_wr_data;
		end
	end

	spd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_disparity (max_disparity_q),
		.up_valid      (in_valid),
		.up_ready      (in_ready),
		.up_word       (in_word),
		.dn_valid      (div_valid[0]),
		.dn_ready      (div_ready[0]),
		.dn_word       (div_word[0])
	);

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		spd_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_valid[i]),
			.up_ready (div_ready[i]),
			.up_word  (div_word[i]),
			.dn_valid (div_valid[i+1]),
			.dn_ready (div_ready[i+1]),
			.dn_word  (div_word[i+1])
		);
	end

	// Output stage: apply the zero and saturation cases, then add or subtract
	// the fraction from the scaled integer disparity (zero result when that is zero).
	always_comb begin
		if (div_word[FRAC_BITS].zero) begin
			mag = '0;
		end else if (div_word[FRAC_BITS].sat) begin
			mag = '1;
		end else begin
			mag = div_word[FRAC_BITS].quot;
		end
		neg  = div_word[FRAC_BITS].neg && !div_word[FRAC_BITS].zero;
		base = {div_word[FRAC_BITS].disp, {FRAC_BITS{1'b0}}};
		if (div_word[FRAC_BITS].disp == '0) begin
			word_d.refined_disparity = '0;
		end else if (neg) begin
			word_d.refined_disparity = base - {{DISP_BITS{1'b0}}, mag};
		end else begin
			word_d.refined_disparity = base + {{DISP_BITS{1'b0}}, mag};
		end
		word_d.fraction_magnitude = mag;
		word_d.fraction_negative  = neg;
	end

	assign ready_s3 = !valid_s3 || out_ready;
	assign div_ready[FRAC_BITS] = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= div_valid[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && div_valid[FRAC_BITS]) begin
			word_s3 <= word_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_word  = word_s3;

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench for subpixel_parabola_disparity_q8: directed and random pixel words under
// random idling on both channels, checked against an in-bench parabola fit predictor.
// Depends on spd_pkg and the top level of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
	import spd_pkg::*;

	localparam int LATENCY     = FRAC_BITS + 3;
	localparam int SETTLE      = LATENCY + 4;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_WORDS = 200;

	// Holds its own copy of the level register and predicts each result word in order.
	class disparity_checker;
		logic [LEVEL_BITS-1:0] max_disparity;
		out_word_t pending_words[$];
		int unsigned errors;

		function new();
			max_disparity = MAX_DISP_RESET;
			errors = 0;
		endfunction

		function void write_levels(logic [LEVEL_BITS-1:0] v);
			max_disparity = v;
		endfunction

		function out_word_t fit_parabola(in_word_t w);
			longint c0, c1, c2, num, den, an, ad, mag, refined;
			int unsigned levels;
			out_word_t r;
			levels = (max_disparity < MIN_LEVELS) ? MIN_LEVELS : max_disparity;
			c1 = w.cost_center;
			// Missing neighbors are mirrored from the other side.
			c0 = (w.int_disparity == 0) ? w.cost_above : w.cost_below;
			c2 = (w.int_disparity + 1 >= levels) ? w.cost_below : w.cost_above;
			num = c0 - c2;
			den = 2 * c0 + 2 * c2 - 4 * c1;
			mag = 0;
			r.fraction_negative = 1'b0;
			if (den != 0 && num != 0) begin
				an = (num < 0) ? -num : num;
				ad = (den < 0) ? -den : den;
				mag = (an << FRAC_BITS) / ad;
				if (mag > (1 << FRAC_BITS) - 1)
					mag = (1 << FRAC_BITS) - 1;
				r.fraction_negative = (num < 0) != (den < 0);
			end
			if (w.int_disparity == 0)
				refined = 0;
			else if (r.fraction_negative)
				refined = (longint'(w.int_disparity) << FRAC_BITS) - mag;
			else
				refined = (longint'(w.int_disparity) << FRAC_BITS) + mag;
			r.refined_disparity = REFINED_BITS'(refined);
			r.fraction_magnitude = FRAC_BITS'(mag);
			return r;
		endfunction

		function void note_input(in_word_t w);
			pending_words = {pending_words, fit_parabola(w)};
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_word;
			if (pending_words.size() == 0) begin
				$error("result word with no expectation waiting: %h", got);
				errors++;
				return;
			end
			exp_word = pending_words.pop_front();
			if (got.refined_disparity !== exp_word.refined_disparity) begin
				$error("refined_disparity: expected %0d, got %0d",
					exp_word.refined_disparity, got.refined_disparity);
				errors++;
			end
			if (got.fraction_magnitude !== exp_word.fraction_magnitude) begin
				$error("fraction_magnitude: expected %0d, got %0d",
					exp_word.fraction_magnitude, got.fraction_magnitude);
				errors++;
			end
			if (got.fraction_negative !== exp_word.fraction_negative) begin
				$error("fraction_negative: expected %0d, got %0d",
					exp_word.fraction_negative, got.fraction_negative);
				errors++;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [LEVEL_BITS-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;

	disparity_checker sb = new();
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	int unsigned cur_levels = MAX_DISP_RESET;
	int unsigned stall_cycles = 0;

	subpixel_parabola_disparity_q8 uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap(bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t pixel(logic [7:0] d, logic [15:0] below, logic [15:0] center,
			logic [15:0] above);
		in_word_t w;
		w.int_disparity = d;
		w.cost_below = below;
		w.cost_center = center;
		w.cost_above = above;
		return w;
	endfunction

	function automatic in_word_t random_pixel(int unsigned levels);
		in_word_t w;
		int unsigned tmp;
		int unsigned base;
		int unsigned delta;
		case ($urandom_range(0, 9))
			0: w.int_disparity = 8'd0;
			1: w.int_disparity = 8'd1;
			2: w.int_disparity = 8'hFF;
			3, 4: begin
				// Land around the top level, where the upper neighbor is mirrored.
				tmp = ((levels < 2) ? 2 : levels) - 2 + $urandom_range(0, 2);
				w.int_disparity = (tmp > 255) ? 8'hFF : 8'(tmp);
			end
			default: w.int_disparity = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 7))
			0, 1: begin
				w.cost_below = 16'($urandom_range(0, 65535));
				w.cost_center = 16'($urandom_range(0, 65535));
				w.cost_above = 16'($urandom_range(0, 65535));
			end
			2, 3: begin
				// A proper minimum at the center with random neighbors above it.
				base = $urandom_range(0, 65535);
				w.cost_center = 16'(base);
				w.cost_below = 16'(base + $urandom_range(0, 65535 - base));
				w.cost_above = 16'(base + $urandom_range(0, 65535 - base));
			end
			4: begin
				// Neighbors symmetric about the center slope give a zero denominator.
				base = $urandom_range(0, 32767);
				delta = $urandom_range(0, base);
				w.cost_center = 16'(base);
				w.cost_below = 16'(base - delta);
				w.cost_above = 16'(base + delta);
				if ($urandom_range(0, 1)) begin
					w.cost_below = 16'(base + delta);
					w.cost_above = 16'(base - delta);
				end
			end
			5: begin
				w.cost_below = $urandom_range(0, 1) ? 16'hFFFF : 16'(($urandom_range(0, 1)));
				w.cost_center = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				w.cost_above = $urandom_range(0, 1) ? 16'hFFFE : 16'h0000;
			end
			6: begin
				// Nearly equal neighbors far above the center: offsets below one step.
				base = $urandom_range(30000, 65534);
				w.cost_below = 16'(base);
				w.cost_above = 16'(base + $urandom_range(0, 1));
				w.cost_center = 16'($urandom_range(0, 100));
				if ($urandom_range(0, 1)) begin
					w.cost_below = w.cost_above;
					w.cost_above = 16'(base);
				end
			end
			default: begin
				w.cost_below = 16'($urandom_range(0, 65535));
				w.cost_above = w.cost_below;
				w.cost_center = 16'($urandom_range(0, 65535));
			end
		endcase
		return w;
	endfunction

	// Called at a rising edge; returns at the edge where the word is accepted.
	task automatic send_word(in_word_t w, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// The first edge lets the monitor note a word accepted at the calling edge.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_levels(logic [LEVEL_BITS-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_levels(v);
		cur_levels = v;
	endtask

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin : result_sink
		int n;
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				n = pick_gap(no_idle);
				if (n == 0) begin
					out_ready <= 1'b1;
					@(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(in_word);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_word);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else if (stall_cycles == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : stimulus
		logic [LEVEL_BITS-1:0] plan[8];
		int phase;
		int n;
		plan = '{9'd2, 9'd256, 9'd0, 9'd1, 9'd511, 9'd100, 9'd64, 9'd0};
		plan[7] = LEVEL_BITS'($urandom_range(2, 256));
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		in_word <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset level count of 64.
		send_word(pixel(8'd0, 16'hFFFF, 16'd100, 16'd200), pick_gap(1'b0));
		send_word(pixel(8'd0, 16'd0, 16'hFFFF, 16'd0), pick_gap(1'b0));
		send_word(pixel(8'd10, 16'd100, 16'd50, 16'd80), pick_gap(1'b0));
		send_word(pixel(8'd10, 16'd80, 16'd50, 16'd100), pick_gap(1'b0));
		send_word(pixel(8'd20, 16'd100, 16'd100, 16'd100), pick_gap(1'b0));
		send_word(pixel(8'd20, 16'd10, 16'd20, 16'd30), pick_gap(1'b0));
		send_word(pixel(8'd30, 16'd500, 16'd200, 16'd500), pick_gap(1'b0));
		send_word(pixel(8'd40, 16'd1000, 16'd0, 16'd1001), pick_gap(1'b0));
		send_word(pixel(8'd40, 16'd1001, 16'd0, 16'd1000), pick_gap(1'b0));
		send_word(pixel(8'd50, 16'd100, 16'd40, 16'd0), pick_gap(1'b0));
		send_word(pixel(8'd1, 16'd0, 16'd40, 16'd100), pick_gap(1'b0));
		send_word(pixel(8'd63, 16'd100, 16'd40, 16'hFFFF), pick_gap(1'b0));
		send_word(pixel(8'd62, 16'd100, 16'd40, 16'hFFFF), pick_gap(1'b0));
		send_word(pixel(8'd200, 16'd7, 16'd3, 16'd9), pick_gap(1'b0));
		send_word(pixel(8'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap(1'b0));
		send_word(pixel(8'd5, 16'hFFFF, 16'd0, 16'd0), pick_gap(1'b0));
		send_word(pixel(8'd5, 16'd0, 16'hFFFF, 16'hFFFF), pick_gap(1'b0));
		send_word(pixel(8'd128, 16'h5555, 16'hAAAA, 16'h0F0F), pick_gap(1'b0));
		send_word(pixel(8'd255, 16'd1, 16'd0, 16'd2), pick_gap(1'b0));
		send_word(pixel(8'd255, 16'd0, 16'hFFFF, 16'd0), pick_gap(1'b0));

		for (phase = 0; phase < 8; phase++) begin
			drain_and_settle();
			write_levels(plan[phase]);
			for (n = 0; n < PHASE_WORDS; n++) begin
				no_idle = (n >= 120 && n < 160);
				if (phase == 1 && n == 50)
					hold_request = 1'b1;
				send_word(random_pixel(cur_levels), pick_gap(no_idle));
			end
			no_idle = 1'b0;
		end

		drain_and_settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
